// ===== sv/awb_pkg.sv =====
// Package for the alpha weighted blend: channel widths, pixel payload types
// and the per-stage word that travels down the divider pipeline.
// No dependencies.
package awb_pkg;

  localparam int CB     = 16;          // bits per color / alpha channel
  localparam int AW     = CB + 1;      // summed alpha width
  localparam int NW     = 2 * CB + 1;  // weighted numerator width
  localparam int NUM_CH = 3;           // red, green, blue

  typedef struct packed {
    logic [CB-1:0] in_red;
    logic [CB-1:0] in_green;
    logic [CB-1:0] in_blue;
    logic [CB-1:0] in_alpha;
    logic [CB-1:0] aux_red;
    logic [CB-1:0] aux_green;
    logic [CB-1:0] aux_blue;
    logic [CB-1:0] aux_alpha;
    logic          last_pixel;
  } in_t;

  typedef struct packed {
    logic [CB-1:0] out_red;
    logic [CB-1:0] out_green;
    logic [CB-1:0] out_blue;
    logic [AW-1:0] out_alpha;
    logic          last_out;
  } out_t;

  // Per-pixel control that rides along the pipeline
  typedef struct packed {
    logic          valid;
    logic          zero;      // summed alpha is zero: force all outputs to 0
    logic          last;
    logic [AW-1:0] alpha;     // result alpha
    logic [AW-1:0] divisor;
  } ctl_t;

  // Restoring divider state for one channel: partial remainder and the
  // dividend bits still to shift in, which fill up with quotient bits.
  typedef struct packed {
    logic [AW-1:0] rem;
    logic [CB-1:0] low;
  } div_ch_t;

  typedef struct packed {
    ctl_t                      ctl;
    div_ch_t [NUM_CH-1:0]      ch;
  } div_word_t;

endpackage

// ===== sv/awb_front.sv =====
// Front end of the blend pipeline: alpha-weighted products, then the
// rounded numerators. Two register stages. Depends on awb_pkg.
module awb_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  awb_pkg::in_t       in_data,
  input  logic               aux_enable,
  output awb_pkg::div_word_t dout
);

  logic [2*awb_pkg::CB-1:0] prod1_r [awb_pkg::NUM_CH];
  logic [2*awb_pkg::CB-1:0] prod2_r [awb_pkg::NUM_CH];
  logic [2*awb_pkg::CB-1:0] prod1_nxt [awb_pkg::NUM_CH];
  logic [2*awb_pkg::CB-1:0] prod2_nxt [awb_pkg::NUM_CH];
  logic [awb_pkg::AW-1:0]   half_r, half_nxt;
  awb_pkg::ctl_t            ctl_r, ctl_nxt;
  awb_pkg::div_word_t       word_r, word_nxt;

  logic [awb_pkg::CB-1:0]   wt1, wt2;
  logic [awb_pkg::AW-1:0]   asum;
  logic [awb_pkg::CB-1:0]   c1 [awb_pkg::NUM_CH];
  logic [awb_pkg::CB-1:0]   c2 [awb_pkg::NUM_CH];

  assign c1[0] = in_data.in_red;
  assign c1[1] = in_data.in_green;
  assign c1[2] = in_data.in_blue;
  assign c2[0] = in_data.aux_red;
  assign c2[1] = in_data.aux_green;
  assign c2[2] = in_data.aux_blue;

  // Pass-through runs as a weight of one on the first pixel over a divisor
  // of one, so the divider hands back the first color unchanged.
  always_comb begin
    asum = {1'b0, in_data.in_alpha} + {1'b0, in_data.aux_alpha};
    if (aux_enable) begin
      wt1             = in_data.in_alpha;
      wt2             = in_data.aux_alpha;
      ctl_nxt.divisor = asum;
      ctl_nxt.alpha   = asum;
      ctl_nxt.zero    = (asum == '0);
    end else begin
      wt1             = {{(awb_pkg::CB-1){1'b0}}, 1'b1};
      wt2             = '0;
      ctl_nxt.divisor = {{(awb_pkg::AW-1){1'b0}}, 1'b1};
      ctl_nxt.alpha   = {1'b0, in_data.in_alpha};
      ctl_nxt.zero    = 1'b0;
    end
    ctl_nxt.valid = in_valid;
    ctl_nxt.last  = in_data.last_pixel;
    half_nxt      = ctl_nxt.divisor >> 1;
    for (int i = 0; i < awb_pkg::NUM_CH; i++) begin
      prod1_nxt[i] = wt1 * c1[i];
      prod2_nxt[i] = wt2 * c2[i];
    end
  end

  always_comb begin
    word_nxt.ctl = ctl_r;
    for (int i = 0; i < awb_pkg::NUM_CH; i++) begin
      {word_nxt.ch[i].rem, word_nxt.ch[i].low} =
          {1'b0, prod1_r[i]} + {1'b0, prod2_r[i]}
          + {{(awb_pkg::NW-awb_pkg::AW){1'b0}}, half_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid      <= 1'b0;
      word_r.ctl.valid <= 1'b0;
    end else if (adv) begin
      ctl_r   <= ctl_nxt;
      half_r  <= half_nxt;
      prod1_r <= prod1_nxt;
      prod2_r <= prod2_nxt;
      word_r  <= word_nxt;
    end
  end

  assign dout = word_r;

endmodule

// ===== sv/awb_div.sv =====
// Pipelined restoring divider, one quotient bit per stage for all three
// color channels in parallel. Depends on awb_pkg.
module awb_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  awb_pkg::div_word_t din,
  output awb_pkg::div_word_t dout
);

  localparam int STEPS = awb_pkg::CB;

  awb_pkg::div_word_t stage_r   [STEPS];
  awb_pkg::div_word_t stage_nxt [STEPS];

  // Numerator < divisor << CB, so the top AW bits already sit below the
  // divisor and CB steps give the full quotient.
  function automatic awb_pkg::div_ch_t div_step(awb_pkg::div_ch_t c,
                                                logic [awb_pkg::AW-1:0] d);
    logic [awb_pkg::AW:0] trial;
    logic [awb_pkg::AW:0] diff;
    logic                 ge;
    awb_pkg::div_ch_t     r;
    trial  = {c.rem, c.low[awb_pkg::CB-1]};
    diff   = trial - {1'b0, d};
    ge     = (trial >= {1'b0, d});
    r.rem  = ge ? diff[awb_pkg::AW-1:0] : trial[awb_pkg::AW-1:0];
    r.low  = {c.low[awb_pkg::CB-2:0], ge};
    return r;
  endfunction

  for (genvar s = 0; s < STEPS; s++) begin : g_stage
    awb_pkg::div_word_t src;
    if (s == 0) begin : g_first
      assign src = din;
    end else begin : g_next
      assign src = stage_r[s-1];
    end

    always_comb begin
      stage_nxt[s].ctl = src.ctl;
      for (int i = 0; i < awb_pkg::NUM_CH; i++) begin
        stage_nxt[s].ch[i] = div_step(src.ch[i], src.ctl.divisor);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_r[s].ctl.valid <= 1'b0;
      end else if (adv) begin
        stage_r[s] <= stage_nxt[s];
      end
    end
  end

  assign dout = stage_r[STEPS-1];

endmodule

// ===== sv/alpha_weighted_blend_top.sv =====
// Channel   Ports                          Direction
// input     in_valid / in_stall / in_data  pixel pair in
// result    out_valid / out_stall / out_data blended pixel out
// config    cfg_we / cfg_wdata             aux_enable write
//
// One pixel pair per clock while in_stall is low; two product/numerator
// stages, one divider stage per quotient bit, one output register.
// The whole pipeline advances together; in_stall rises only while the
// output register holds a result and out_stall is high.
// Reset clears all valid bits and sets aux_enable to 1.
// Top level: register, front end, divider and output register.
// Depends on awb_pkg, awb_front, awb_div.
module alpha_weighted_blend_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  awb_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output awb_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);

  logic               aux_enable_r;
  logic               adv;
  logic               out_valid_r;
  awb_pkg::out_t      out_data_r, out_data_nxt;
  awb_pkg::div_word_t front_word;
  awb_pkg::div_word_t div_word;

  // Every stage moves when the output slot is free or being drained
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aux_enable_r <= 1'b1;
    end else if (cfg_we) begin
      aux_enable_r <= cfg_wdata;
    end
  end

  awb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .aux_enable (aux_enable_r),
    .dout       (front_word)
  );

  awb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .din   (front_word),
    .dout  (div_word)
  );

  always_comb begin
    out_data_nxt.out_alpha = div_word.ctl.alpha;
    out_data_nxt.last_out  = div_word.ctl.last;
    if (div_word.ctl.zero) begin
      out_data_nxt.out_red   = '0;
      out_data_nxt.out_green = '0;
      out_data_nxt.out_blue  = '0;
    end else begin
      out_data_nxt.out_red   = div_word.ch[0].low;
      out_data_nxt.out_green = div_word.ch[1].low;
      out_data_nxt.out_blue  = div_word.ch[2].low;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_word.ctl.valid;
      out_data_r  <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sim/alpha_weighted_blend_top_test.sv =====
// Self-checking testbench for alpha_weighted_blend_top: blend and pass-through
// pixels with random gaps, random output stalls and one long output hold-off.
// Depends on awb_pkg and the alpha_weighted_blend_top RTL.
`timescale 1ns / 100ps

module alpha_weighted_blend_top_test;

  localparam int HOLD_CYCLES = 80;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  awb_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  awb_pkg::out_t out_data;
  logic          cfg_we;
  logic          cfg_wdata;

  awb_pkg::out_t expected_blends[$];
  bit   blend_on;          // predictor copy of aux_enable
  int   error_count;
  int   pixels_sent;
  int   results_checked;
  int   cfg_writes;
  int   burst_left;
  bit   no_gaps;
  bit   hold_request;

  alpha_weighted_blend_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("alpha_weighted_blend_top_test: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  // Rounded (a1*c1 + a2*c2) / (a1 + a2), halves round up
  function automatic logic [awb_pkg::CB-1:0] mix_channel(
      input logic [awb_pkg::CB-1:0] c1, a1, c2, a2,
      input logic [awb_pkg::AW-1:0] asum);
    logic [63:0] num;
    logic [63:0] quo;
    num = 64'(a1) * 64'(c1) + 64'(a2) * 64'(c2) + 64'(asum >> 1);
    quo = num / 64'(asum);
    return quo[awb_pkg::CB-1:0];
  endfunction

  function automatic awb_pkg::out_t blend_pixel(input awb_pkg::in_t px, input bit enable);
    awb_pkg::out_t r;
    logic [awb_pkg::AW-1:0] asum;
    r = '0;
    r.last_out = px.last_pixel;
    if (!enable) begin
      r.out_red   = px.in_red;
      r.out_green = px.in_green;
      r.out_blue  = px.in_blue;
      r.out_alpha = {1'b0, px.in_alpha};
    end else begin
      asum = awb_pkg::AW'(px.in_alpha) + awb_pkg::AW'(px.aux_alpha);
      if (asum != '0) begin
        r.out_red   = mix_channel(px.in_red, px.in_alpha, px.aux_red, px.aux_alpha, asum);
        r.out_green = mix_channel(px.in_green, px.in_alpha, px.aux_green, px.aux_alpha, asum);
        r.out_blue  = mix_channel(px.in_blue, px.in_alpha, px.aux_blue, px.aux_alpha, asum);
        r.out_alpha = asum;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic awb_pkg::in_t make_pixel(
      input logic [awb_pkg::CB-1:0] r, g, b, a, xr, xg, xb, xa,
      input logic last);
    awb_pkg::in_t px;
    px.in_red    = r;
    px.in_green  = g;
    px.in_blue   = b;
    px.in_alpha  = a;
    px.aux_red   = xr;
    px.aux_green = xg;
    px.aux_blue  = xb;
    px.aux_alpha = xa;
    px.last_pixel = last;
    return px;
  endfunction

  // Biased toward zero, full scale and values next to them
  function automatic logic [awb_pkg::CB-1:0] rand_channel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return awb_pkg::CB'($urandom_range(0, 15));
      3: return '1 - awb_pkg::CB'($urandom_range(0, 15));
      default: return awb_pkg::CB'($urandom);
    endcase
  endfunction

  function automatic awb_pkg::in_t random_pixel();
    return make_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel(),
                      rand_channel(), rand_channel(), rand_channel(), rand_channel(),
                      ($urandom_range(0, 7) == 0));
  endfunction

  // One transfer on the input channel; bursts of random length with random gaps
  task automatic send_pixel(input awb_pkg::in_t px);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
    expected_blends.push_back(blend_pixel(px, blend_on));
    pixels_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_blends.size() != 0) @(posedge clk);
  endtask

  // Only written with the pipeline empty
  task automatic write_aux_enable(input bit value);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    blend_on   = value;
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_blend();
    send_pixel(make_pixel('1, '1, '1, '0, '1, '1, '1, '0, 1'b0));      // both alphas zero
    send_pixel(make_pixel('0, '0, '0, '0, '0, '0, '0, '0, 1'b1));
    send_pixel(make_pixel('1, '0, '1, '1, '0, '1, 16'h1234, '1, 1'b0));
    send_pixel(make_pixel('1, '1, '1, '1, '1, '1, '1, '1, 1'b1));      // alpha sum at max
    send_pixel(make_pixel(16'h1111, 16'h2222, 16'h3333, '0, '1, '0, 16'h8000, '1, 1'b0));
    send_pixel(make_pixel('1, '0, 16'h8000, '1, 16'h1111, 16'h2222, 16'h3333, '0, 1'b0));
    send_pixel(make_pixel('0, '0, '0, 16'd1, 16'd1, 16'd3, '1, 16'd1, 1'b0)); // exact halves
    send_pixel(make_pixel('1, '0, 16'd7, 16'd1, '0, '1, 16'd8, '0, 1'b1));
    send_pixel(make_pixel(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                          16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0));
    send_pixel(make_pixel('1, '1, '0, 16'd1, '0, '0, '1, '1, 1'b0));
    send_pixel(make_pixel(16'd2, 16'd3, 16'd4, 16'd3, 16'd5, 16'd6, 16'd7, 16'd3, 1'b1));
  endtask

  task automatic test_directed_passthrough();
    send_pixel(make_pixel('1, '1, '1, '1, '0, '0, '0, '0, 1'b0));
    send_pixel(make_pixel('0, '0, '0, '0, '1, '1, '1, '1, 1'b1));      // zero alpha still copies
    send_pixel(make_pixel(16'h8001, 16'h7FFE, 16'h00FF, '0, '0, '0, '0, '0, 1'b0));
    send_pixel(make_pixel(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                          awb_pkg::CB'($urandom), awb_pkg::CB'($urandom),
                          awb_pkg::CB'($urandom), awb_pkg::CB'($urandom), 1'b1));
    send_pixel(make_pixel('0, '1, '0, 16'h8000, '1, '0, '1, '1, 1'b0));
  endtask

  task automatic test_random(input int count);
    repeat (count) send_pixel(random_pixel());
  endtask

  // Receiver holds off while the sender keeps offering, so in_stall must rise
  task automatic test_backpressure();
    no_gaps = 1'b1;
    hold_request = 1'b1;
    repeat (70) send_pixel(random_pixel());
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin : receiver
    int seg_left;
    int mode;
    int hold_left;
    out_stall = 1'b0;
    seg_left  = 0;
    mode      = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request && hold_left == 0) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(10, 60);
        end
        seg_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 6);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- checker

  task automatic compare_field(input string name, input int unsigned want, got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    awb_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_blends.size() == 0) begin
        $error("result transfer with no pixel outstanding: %p", out_data);
        error_count++;
      end else begin
        want = expected_blends.pop_front();
        compare_field("out_red", want.out_red, out_data.out_red);
        compare_field("out_green", want.out_green, out_data.out_green);
        compare_field("out_blue", want.out_blue, out_data.out_blue);
        compare_field("out_alpha", want.out_alpha, out_data.out_alpha);
        compare_field("last_out", want.last_out, out_data.last_out);
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = 1'b0;
    blend_on     = 1'b1;     // reset value of aux_enable
    error_count  = 0;
    pixels_sent  = 0;
    results_checked = 0;
    cfg_writes   = 0;
    burst_left   = 0;
    no_gaps      = 1'b0;
    hold_request = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_blend();
    write_aux_enable(1'b0);
    test_directed_passthrough();
    write_aux_enable(1'b1);
    test_random(200);
    write_aux_enable(1'b0);
    test_random(90);
    write_aux_enable(1'b1);
    test_backpressure();
    test_random(170);

    wait_drain();
    repeat (25) @(posedge clk);   // catch stray results after the last one
    $display("Sent %0d pixel pairs over %0d aux_enable writes (blend and pass-through),",
             pixels_sent, cfg_writes);
    $display("checked %0d results under random gaps, stalls and a long output hold-off.",
             results_checked);
    if (error_count == 0 && expected_blends.size() == 0) begin
      $display("alpha_weighted_blend_top_test: done, clean");
    end else begin
      $display("alpha_weighted_blend_top_test: done, errors");
    end
    $finish;
  end

endmodule
